### design/signed_int_to_decimal_ascii_assert.svh
// Assertion macros shared by the signed integer to decimal text block.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SIDEC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SIDEC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/sidec_pkg.sv
// Shared types, constants and the microprogram of the decimal text converter.
// No dependencies; imported by the sequencer, the datapath and the top level.
package sidec_pkg;

  localparam int BIN_W  = 32;
  localparam int DIG_N  = 10;
  localparam int BCD_W  = 4 * DIG_N;
  localparam int CHAR_W = 8;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;

  typedef logic [2:0] step_t;

  localparam step_t STEP_LOAD  = 3'd0;
  localparam step_t STEP_CONV  = 3'd1;
  localparam step_t STEP_SKIP  = 3'd2;
  localparam step_t STEP_SIGN  = 3'd3;
  localparam step_t STEP_DIGIT = 3'd4;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_DABBLE,
    OP_SKIP,
    OP_SIGN,
    OP_DIGIT
  } op_t;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_IN_TAKE,
    C_CONV_MORE,
    C_SKIP_MORE,
    C_OUT_HOLD,
    C_DIGIT_REPEAT
  } cond_t;

  // One control word: an operation, a branch condition and two targets.
  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t tgt_true;
    step_t tgt_false;
  } uword_t;

  typedef struct packed {
    op_t  op;
    logic in_take;
    logic out_take;
  } ctrl_t;

  typedef struct packed {
    logic neg;
    logic conv_more;
    logic skip_more;
    logic last_digit;
  } status_t;

  function automatic uword_t ucode_rom(input step_t pc);
    uword_t w;
    unique case (pc)
      STEP_LOAD:  w = '{OP_LOAD,   C_IN_TAKE,      STEP_CONV,  STEP_LOAD};
      STEP_CONV:  w = '{OP_DABBLE, C_CONV_MORE,    STEP_CONV,  STEP_SKIP};
      STEP_SKIP:  w = '{OP_SKIP,   C_SKIP_MORE,    STEP_SKIP,  STEP_SIGN};
      STEP_SIGN:  w = '{OP_SIGN,   C_OUT_HOLD,     STEP_SIGN,  STEP_DIGIT};
      STEP_DIGIT: w = '{OP_DIGIT,  C_DIGIT_REPEAT, STEP_DIGIT, STEP_LOAD};
      default:    w = '{OP_LOAD,   C_ALWAYS,       STEP_LOAD,  STEP_LOAD};
    endcase
    return w;
  endfunction

endpackage

### design/sidec_seq.sv
// Microprogram sequencer: step counter, control word fetch and branch logic.
// Depends on sidec_pkg and the assertion macro header.
`include "signed_int_to_decimal_ascii_assert.svh"

module sidec_seq import sidec_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    value_valid,
  output logic    value_stall,
  output logic    char_valid,
  input  logic    char_stall,
  input  status_t status,
  output ctrl_t   ctrl
);

  step_t  pc;
  step_t  pc_next;
  uword_t uw;
  logic   cond_hit;

  assign uw = ucode_rom(pc);

  // Output decode.
  always_comb begin
    value_stall   = (uw.op != OP_LOAD);
    char_valid    = (uw.op == OP_DIGIT) || ((uw.op == OP_SIGN) && status.neg);
    ctrl.op       = uw.op;
    ctrl.in_take  = (uw.op == OP_LOAD) && value_valid;
    ctrl.out_take = char_valid && !char_stall;
  end

  // Branch decision and next step.
  always_comb begin
    unique case (uw.cond)
      C_ALWAYS:       cond_hit = 1'b1;
      C_IN_TAKE:      cond_hit = ctrl.in_take;
      C_CONV_MORE:    cond_hit = status.conv_more;
      C_SKIP_MORE:    cond_hit = status.skip_more;
      C_OUT_HOLD:     cond_hit = char_valid && !ctrl.out_take;
      C_DIGIT_REPEAT: cond_hit = !ctrl.out_take || !status.last_digit;
      default:        cond_hit = 1'b1;
    endcase
    pc_next = cond_hit ? uw.tgt_true : uw.tgt_false;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_LOAD;
    end else begin
      pc <= pc_next;
    end
  end

  `SIDEC_ASSERT_NXT(a_take_starts_conv, ctrl.in_take, pc == STEP_CONV,
                    "load did not start conversion")
  `SIDEC_ASSERT_NXT(a_last_returns,
                    ctrl.out_take && (uw.op == OP_DIGIT) && status.last_digit,
                    pc == STEP_LOAD, "last digit did not return to load")

endmodule

### design/sidec_dpath.sv
// Datapath: magnitude, binary to BCD shift register, digit count and character output.
// Depends on sidec_pkg and the assertion macro header.
`include "signed_int_to_decimal_ascii_assert.svh"

module sidec_dpath import sidec_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [BIN_W-1:0]  value,
  input  ctrl_t             ctrl,
  output status_t           status,
  output logic [CHAR_W-1:0] character,
  output logic              final_char
);

  localparam int WORK_W = BCD_W + BIN_W;

  logic [BCD_W-1:0]  bcd;
  logic [BIN_W-1:0]  bin;
  logic [2:0]        conv_cnt;
  logic [3:0]        left;
  logic              neg;
  logic [WORK_W-1:0] work_next;
  logic [BIN_W-1:0]  mag;
  logic [3:0]        top_digit;

  // Four shift-and-add-3 steps: four input bits enter the BCD digits.
  function automatic logic [WORK_W-1:0] dabble4(input logic [WORK_W-1:0] w);
    logic [WORK_W-1:0] t;
    logic [3:0]        d;
    t = w;
    for (int s = 0; s < 4; s++) begin
      for (int k = 0; k < DIG_N; k++) begin
        d = t[BIN_W + 4*k +: 4];
        if (d >= 4'd5) begin
          t[BIN_W + 4*k +: 4] = d + 4'd3;
        end
      end
      t = {t[WORK_W-2:0], 1'b0};
    end
    return t;
  endfunction

  assign work_next = dabble4({bcd, bin});
  assign mag       = value[BIN_W-1] ? (BIN_W'(0) - value) : value;
  assign top_digit = bcd[BCD_W-1 -: 4];

  always_comb begin
    status.neg        = neg;
    status.conv_more  = (conv_cnt != 3'd7);
    status.skip_more  = (top_digit == 4'd0) && (left != 4'd1);
    status.last_digit = (left == 4'd1);
    character  = (ctrl.op == OP_SIGN) ? ASCII_MINUS : (ASCII_ZERO + {4'd0, top_digit});
    final_char = (ctrl.op == OP_DIGIT) && (left == 4'd1);
  end

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_LOAD: begin
        if (ctrl.in_take) begin
          bcd      <= '0;
          bin      <= mag;
          neg      <= value[BIN_W-1];
          conv_cnt <= 3'd0;
          left     <= 4'(DIG_N);
        end
      end
      OP_DABBLE: begin
        {bcd, bin} <= work_next;
        conv_cnt   <= conv_cnt + 3'd1;
      end
      OP_SKIP: begin
        if (status.skip_more) begin
          bcd  <= {bcd[BCD_W-5:0], 4'd0};
          left <= left - 4'd1;
        end
      end
      OP_SIGN: begin
      end
      OP_DIGIT: begin
        if (ctrl.out_take) begin
          bcd  <= {bcd[BCD_W-5:0], 4'd0};
          left <= left - 4'd1;
        end
      end
      default: begin
      end
    endcase
  end

  `SIDEC_ASSERT_NXT(a_skip_counts, (ctrl.op == OP_SKIP) && status.skip_more,
                    left == $past(left) - 4'd1, "skip did not drop a digit")
  `SIDEC_ASSERT_IMP(a_digit_is_decimal, ctrl.op == OP_DIGIT,
                    (top_digit <= 4'd9) && (left != 4'd0), "emitted digit out of range")

endmodule

### design/signed_int_to_decimal_ascii.sv
// Top level of the signed 32-bit integer to decimal ASCII converter.
// Depends on sidec_pkg, sidec_seq and sidec_dpath.

// One word on the value channel is a signed 32-bit integer; the block answers
// with its decimal text on the char channel, one ASCII character per word, most
// significant first: a leading '-' for negative numbers, then the digits with
// no leading zeros, and final_char set on the last character. Zero gives "0"
// and the most negative value gives "-2147483648", so an input yields one to
// eleven output words. Both channels handshake with valid and stall; a word
// moves on a rising edge where valid is high and stall is low. The block works
// on one number at a time under a small microprogram: a load step, eight
// double dabble steps that fold four magnitude bits per cycle into ten BCD
// digits, leading-zero removal, a sign step and the digit output. It takes no
// new number until its last character has moved, and an output stall holds
// the sequence in the sign or digit step until the character is taken.
module signed_int_to_decimal_ascii import sidec_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [BIN_W-1:0]  value,
  input  logic              value_valid,
  output logic              value_stall,
  output logic [CHAR_W-1:0] character,
  output logic              final_char,
  output logic              char_valid,
  input  logic              char_stall
);

  ctrl_t   ctrl;
  status_t status;

  // The sequencer fetches a control word per step and decides the branch.
  sidec_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .value_valid (value_valid),
    .value_stall (value_stall),
    .char_valid  (char_valid),
    .char_stall  (char_stall),
    .status      (status),
    .ctrl        (ctrl)
  );

  // The datapath holds the magnitude, the BCD digits and the digit count.
  sidec_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .value      (value),
    .ctrl       (ctrl),
    .status     (status),
    .character  (character),
    .final_char (final_char)
  );

endmodule
